FILE: rtl/jse_pkg.sv
// Shared types, character codes and helpers for the JSON string escaper.
// No dependencies; imported by jse_decode, jse_emit, json_string_escaper and the testbench.
`default_nettype none

package jse_pkg;

    // Longest escape burst: backslash, 'u' and six hex digits
    localparam int unsigned BURST_MAX   = 8;
    localparam int unsigned BURST_IDX_W = $clog2(BURST_MAX);
    localparam int unsigned CODE_W      = 21;

    // Characters that get a backslash in front of themselves
    localparam logic [7:0] CH_QUOTE   = 8'h22;
    localparam logic [7:0] CH_APOS    = 8'h27;
    localparam logic [7:0] CH_BSLASH  = 8'h5C;
    localparam logic [7:0] CH_SLASH   = 8'h2F;

    // Control characters with short escapes, and their letters
    localparam logic [7:0] CH_BS      = 8'h08;
    localparam logic [7:0] CH_FF      = 8'h0C;
    localparam logic [7:0] CH_LF      = 8'h0A;
    localparam logic [7:0] CH_CR      = 8'h0D;
    localparam logic [7:0] CH_TAB     = 8'h09;
    localparam logic [7:0] CH_LOW_B   = 8'h62;
    localparam logic [7:0] CH_LOW_F   = 8'h66;
    localparam logic [7:0] CH_LOW_N   = 8'h6E;
    localparam logic [7:0] CH_LOW_R   = 8'h72;
    localparam logic [7:0] CH_LOW_T   = 8'h74;
    localparam logic [7:0] CH_LOW_U   = 8'h75;

    // UTF-8 lead byte limits
    localparam logic [7:0] LEAD_TWO   = 8'h80;
    localparam logic [7:0] LEAD_THREE = 8'hE0;
    localparam logic [7:0] LEAD_FOUR  = 8'hF0;
    localparam logic [7:0] LEAD_BAD   = 8'hF8;

    // Printable range written as the raw lead byte
    localparam logic [CODE_W-1:0] CODE_PRINT_LO = 21'h20;
    localparam logic [CODE_W-1:0] CODE_PRINT_HI = 21'h80;
    localparam logic [CODE_W-1:0] CODE_FOUR_MAX = 21'h0FFFF;
    localparam logic [CODE_W-1:0] CODE_FIVE_MAX = 21'hFFFFF;

    // One request's worth of output characters, ch[0] goes out first
    typedef struct packed {
        logic [BURST_MAX-1:0][7:0] ch;
        logic [BURST_IDX_W-1:0]    last_idx;
    } t_burst;

    // Lowercase hex digit
    function automatic logic [7:0] hex_char(input logic [3:0] nib);
        logic [7:0] ext;
        ext = {4'h0, nib};
        return (nib < 4'd10) ? (8'h30 + ext) : (8'h57 + ext);
    endfunction

endpackage

`default_nettype wire

FILE: rtl/json_string_escaper.sv
// JSON string escaper: input register, then result register, then the output characters.
// Throughput is one byte per cycle while each byte gives at most one character and the receiver
// is ready; a byte that gives n characters (2, 6, 7 or 8) holds the result register until the
// one-character output port has sent them all. Bytes that do not close a UTF-8 sequence
// give nothing and pass at one per cycle. Synchronous active-low reset empties both registers
// and clears the decode state. Depends on jse_pkg, jse_decode and jse_emit.
`default_nettype none

module json_string_escaper
    import jse_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       s_axis_tvalid,
    output logic            s_axis_tready,
    input  wire logic [7:0] s_axis_tdata,   // [7:0] in_byte
    input  wire logic       s_axis_tlast,   // end_of_string
    output logic            m_axis_tvalid,
    input  wire logic       m_axis_tready,
    output logic [7:0]      m_axis_tdata,   // [7:0] out_char
    output logic            m_axis_tlast    // run_last
);

    logic   load_ok;
    logic   push;
    t_burst burst;

    jse_decode u_decode (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .i_load_ok     (load_ok),
        .o_push        (push),
        .o_burst       (burst)
    );

    jse_emit u_emit (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_push        (push),
        .i_burst       (burst),
        .o_load_ok     (load_ok),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

endmodule

`default_nettype wire

FILE: rtl/jse_decode.sv
// Input register, UTF-8 decode state and escape formatting for the escaper.
// Depends on jse_pkg; feeds a whole burst of characters to jse_emit.
`default_nettype none

module jse_decode
    import jse_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       s_axis_tvalid,
    output logic            s_axis_tready,
    input  wire logic [7:0] s_axis_tdata,   // [7:0] in_byte
    input  wire logic       s_axis_tlast,   // end_of_string
    input  wire logic       i_load_ok,
    output logic            o_push,
    output t_burst          o_burst
);

    // Input register
    logic       r_valid;
    logic [7:0] r_byte;
    logic       r_eos;

    // Decode state
    logic [1:0]        r_rem;
    logic [CODE_W-1:0] r_acc;
    logic [7:0]        r_lead;
    logic [1:0]        n_rem;
    logic [CODE_W-1:0] n_acc;
    logic [7:0]        n_lead;

    logic   has_out;
    logic   adv;
    t_burst burst;

    // Decode one byte into a burst and the next state
    always_comb begin
        logic [CODE_W-1:0] code;
        logic [7:0]        lead;
        logic              finish;
        logic [7:0]        esc;
        logic              is_esc;
        logic [23:0]       shifted;
        logic [2:0]        nd;

        code    = '0;
        lead    = r_lead;
        finish  = 1'b0;
        esc     = '0;
        is_esc  = 1'b0;
        n_rem   = r_rem;
        n_acc   = r_acc;
        n_lead  = r_lead;
        burst   = '0;
        has_out = 1'b0;
        shifted = '0;
        nd      = 3'd4;

        if (r_rem != 2'd0) begin
            // continuation byte, taken without any check
            code   = {r_acc[CODE_W-7:0], r_byte[5:0]};
            n_rem  = r_rem - 2'd1;
            n_acc  = code;
            finish = (r_rem == 2'd1) || r_eos;
        end else begin
            case (r_byte)
                CH_QUOTE, CH_APOS, CH_BSLASH, CH_SLASH: begin
                    is_esc = 1'b1;
                    esc    = r_byte;
                end
                CH_BS:  begin is_esc = 1'b1; esc = CH_LOW_B; end
                CH_FF:  begin is_esc = 1'b1; esc = CH_LOW_F; end
                CH_LF:  begin is_esc = 1'b1; esc = CH_LOW_N; end
                CH_CR:  begin is_esc = 1'b1; esc = CH_LOW_R; end
                CH_TAB: begin is_esc = 1'b1; esc = CH_LOW_T; end
                default: begin
                    lead   = r_byte;
                    n_lead = r_byte;
                    if (r_byte < LEAD_TWO) begin
                        code  = {13'd0, r_byte};
                        n_rem = 2'd0;
                    end else if (r_byte < LEAD_THREE) begin
                        code  = {16'd0, r_byte[4:0]};
                        n_rem = 2'd1;
                    end else if (r_byte < LEAD_FOUR) begin
                        code  = {17'd0, r_byte[3:0]};
                        n_rem = 2'd2;
                    end else if (r_byte < LEAD_BAD) begin
                        code  = {18'd0, r_byte[2:0]};
                        n_rem = 2'd3;
                    end else begin
                        code  = '0;
                        n_rem = 2'd0;
                    end
                    n_acc  = code;
                    finish = (n_rem == 2'd0) || r_eos;
                end
            endcase
        end

        if (is_esc) begin
            has_out        = 1'b1;
            burst.ch[0]    = CH_BSLASH;
            burst.ch[1]    = esc;
            burst.last_idx = BURST_IDX_W'(1);
        end else if (finish) begin
            has_out = 1'b1;
            if (code < CODE_PRINT_LO || code >= CODE_PRINT_HI) begin
                // \u and four to six hex digits, most significant first
                if (code > CODE_FIVE_MAX) begin
                    nd = 3'd6;
                end else if (code > CODE_FOUR_MAX) begin
                    nd = 3'd5;
                end
                case (nd)
                    3'd6:    shifted = {3'd0, code};
                    3'd5:    shifted = {code[19:0], 4'd0};
                    default: shifted = {code[15:0], 8'd0};
                endcase
                burst.ch[0] = CH_BSLASH;
                burst.ch[1] = CH_LOW_U;
                for (int j = 0; j < 6; j++) begin
                    burst.ch[2 + j] = hex_char(shifted[23 - 4*j -: 4]);
                end
                burst.last_idx = BURST_IDX_W'(nd + 3'd1);
            end else begin
                // printable code: the raw lead byte
                burst.ch[0]    = lead;
                burst.last_idx = '0;
            end
            n_rem  = '0;
            n_acc  = '0;
            n_lead = '0;
        end

        // end of string always clears the sequence
        if (r_eos) begin
            n_rem  = '0;
            n_acc  = '0;
            n_lead = '0;
        end
    end

    // Handshake: a byte with no output never waits for the emit stage
    assign adv           = r_valid && (!has_out || i_load_ok);
    assign s_axis_tready = !r_valid || adv;
    assign o_push        = adv && has_out;
    assign o_burst       = burst;

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tready && s_axis_tvalid) begin
            r_byte <= s_axis_tdata;
            r_eos  <= s_axis_tlast;
        end
    end

    // Decode state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rem  <= '0;
            r_acc  <= '0;
            r_lead <= '0;
        end else if (adv) begin
            r_rem  <= n_rem;
            r_acc  <= n_acc;
            r_lead <= n_lead;
        end
    end

    // A string end leaves no open sequence behind
    a_eos_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (adv && r_eos) |=> (r_rem == 2'd0 && r_acc == '0 && r_lead == '0))
        else $error("decode state not cleared after end of string");

    // Only a byte that leaves the input register produces a burst
    a_push_adv: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_push |-> (r_valid && i_load_ok))
        else $error("burst pushed without a free emit stage");

    // A continuation byte never yields a two-character escape
    a_cont_no_short: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_push && r_rem != 2'd0) |-> (o_burst.last_idx != BURST_IDX_W'(1)))
        else $error("short escape inside a UTF-8 sequence");

endmodule

`default_nettype wire

FILE: rtl/jse_emit.sv
// Result register that holds one burst and sends it out a character at a time.
// Depends on jse_pkg; loaded by jse_decode.
`default_nettype none

module jse_emit
    import jse_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_push,
    input  wire t_burst     i_burst,
    output logic            o_load_ok,
    output logic            m_axis_tvalid,
    input  wire logic       m_axis_tready,
    output logic [7:0]      m_axis_tdata,   // [7:0] out_char
    output logic            m_axis_tlast    // run_last
);

    logic                         r_busy;
    logic [BURST_MAX-1:0][7:0]    r_ch;
    logic [BURST_IDX_W-1:0]       r_last_idx;
    logic [BURST_IDX_W-1:0]       r_idx;
    logic                         at_last;
    logic                         take;

    assign at_last       = (r_idx == r_last_idx);
    assign take          = r_busy && m_axis_tready;
    assign o_load_ok     = !r_busy || (take && at_last);
    assign m_axis_tvalid = r_busy;
    assign m_axis_tdata  = r_ch[r_idx];
    assign m_axis_tlast  = at_last;

    // Burst occupancy and character pointer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_idx  <= '0;
        end else if (i_push) begin
            r_busy <= 1'b1;
            r_idx  <= '0;
        end else if (take) begin
            if (at_last) begin
                r_busy <= 1'b0;
            end else begin
                r_idx <= r_idx + BURST_IDX_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_ch       <= i_burst.ch;
            r_last_idx <= i_burst.last_idx;
        end
    end

    // Pointer never runs past the end of its burst
    a_idx_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> (r_idx <= r_last_idx))
        else $error("character pointer beyond burst end");

    // Every multi-character burst is an escape
    a_esc_head: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_busy && r_idx == '0 && r_last_idx != '0) |-> (m_axis_tdata == CH_BSLASH))
        else $error("multi-character burst without leading backslash");

    // A new burst is only loaded into a free register
    a_load_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> o_load_ok)
        else $error("burst loaded over unsent characters");

endmodule

`default_nettype wire

FILE: tb/testbench.sv
`timescale 1ns / 1ps
// Self-checking bench for json_string_escaper: streams random and directed string bytes,
// predicts the escaped characters in a scoreboard class and compares them one by one.
// Depends on jse_pkg and the json_string_escaper RTL.

module testbench;
    import jse_pkg::*;

    localparam int unsigned RANDOM_BYTES = 204;
    localparam int unsigned CYCLE_LIMIT  = 100000;
    localparam int unsigned HOLD_CYCLES  = 200;
    localparam int unsigned DRAIN_CYCLES = 10;

    localparam logic [7:0] ASCII_ZERO = "0";
    localparam logic [7:0] ASCII_A    = "a";

    // One expected output character with its end-of-burst flag
    typedef struct packed {
        logic [7:0] ch;
        logic       last;
    } t_esc_char;

    // Predicts the escaped characters of each accepted byte and checks the output stream
    class escape_scoreboard;
        logic [1:0]  cont_left;
        logic [20:0] code_acc;
        logic [7:0]  lead_byte;
        logic [7:0]  burst[$];
        t_esc_char   char_q[$];
        int unsigned err_cnt;
        int unsigned char_cnt;
        int unsigned byte_cnt;
        int unsigned string_cnt;

        function new();
            cont_left  = '0;
            code_acc   = '0;
            lead_byte  = '0;
            err_cnt    = 0;
            char_cnt   = 0;
            byte_cnt   = 0;
            string_cnt = 0;
        endfunction

        function int unsigned outstanding();
            return char_q.size();
        endfunction

        function logic [7:0] hex_digit(input logic [3:0] nib);
            if (nib < 4'd10) begin
                return ASCII_ZERO + {4'h0, nib};
            end
            return ASCII_A + {4'h0, nib} - 8'd10;
        endfunction

        function void clear_decode();
            cont_left = '0;
            code_acc  = '0;
            lead_byte = '0;
        endfunction

        // Close the open code: \u plus hex, or the raw lead byte when printable
        function void flush_code();
            int ndig;
            if (code_acc < CODE_PRINT_LO || code_acc >= CODE_PRINT_HI) begin
                ndig = 4;
                if (code_acc > CODE_FOUR_MAX) ndig = 5;
                if (code_acc > CODE_FIVE_MAX) ndig = 6;
                burst.push_back(CH_BSLASH);
                burst.push_back(CH_LOW_U);
                for (int i = ndig - 1; i >= 0; i--) begin
                    burst.push_back(hex_digit(4'(code_acc >> (4 * i))));
                end
            end else begin
                burst.push_back(lead_byte);
            end
            clear_decode();
        endfunction

        function void short_escape(input logic [7:0] letter);
            burst.push_back(CH_BSLASH);
            burst.push_back(letter);
        endfunction

        // Called for every accepted input request
        function void note_byte(input logic [7:0] b, input logic eos);
            t_esc_char c;
            burst.delete();
            byte_cnt++;
            if (eos) string_cnt++;
            if (cont_left != 2'd0) begin
                // inside a sequence every byte is a continuation, whatever it looks like
                code_acc  = {code_acc[14:0], b[5:0]};
                cont_left = cont_left - 2'd1;
                if (cont_left == 2'd0 || eos) flush_code();
            end else begin
                case (b)
                    CH_QUOTE, CH_APOS, CH_BSLASH, CH_SLASH: short_escape(b);
                    CH_BS:  short_escape(CH_LOW_B);
                    CH_FF:  short_escape(CH_LOW_F);
                    CH_LF:  short_escape(CH_LOW_N);
                    CH_CR:  short_escape(CH_LOW_R);
                    CH_TAB: short_escape(CH_LOW_T);
                    default: begin
                        lead_byte = b;
                        if (b < LEAD_TWO) begin
                            code_acc  = {13'h0, b};
                            cont_left = 2'd0;
                        end else if (b < LEAD_THREE) begin
                            code_acc  = {16'h0, b[4:0]};
                            cont_left = 2'd1;
                        end else if (b < LEAD_FOUR) begin
                            code_acc  = {17'h0, b[3:0]};
                            cont_left = 2'd2;
                        end else if (b < LEAD_BAD) begin
                            code_acc  = {18'h0, b[2:0]};
                            cont_left = 2'd3;
                        end else begin
                            // invalid lead: code zero
                            code_acc  = '0;
                            cont_left = 2'd0;
                        end
                        if (cont_left == 2'd0 || eos) flush_code();
                    end
                endcase
            end
            if (eos) clear_decode();
            foreach (burst[i]) begin
                c.ch   = burst[i];
                c.last = (i == burst.size() - 1);
                char_q.push_back(c);
            end
        endfunction

        // Called for every accepted output request
        function void check_char(input logic [7:0] ch, input logic last);
            t_esc_char e;
            if (char_q.size() == 0) begin
                $error("unexpected character out_char=%02h run_last=%0b", ch, last);
                err_cnt++;
                return;
            end
            e = char_q.pop_front();
            char_cnt++;
            if (ch !== e.ch) begin
                $error("out_char: expected %02h, got %02h", e.ch, ch);
                err_cnt++;
            end
            if (last !== e.last) begin
                $error("run_last: expected %0b, got %0b", e.last, last);
                err_cnt++;
            end
        endfunction
    endclass

    logic       i_clk         = 1'b0;
    logic       i_rst_n       = 1'b0;
    logic       s_axis_tvalid = 1'b0;
    logic       s_axis_tready;
    logic [7:0] s_axis_tdata  = 8'h00;
    logic       s_axis_tlast  = 1'b0;
    logic       m_axis_tvalid;
    logic       m_axis_tready = 1'b0;
    logic [7:0] m_axis_tdata;
    logic       m_axis_tlast;

    escape_scoreboard sb = new();
    int unsigned tx_idle_pct = 16;
    int unsigned rx_idle_pct = 16;
    bit          hold_req    = 1'b0;
    int unsigned hold_cnt    = 0;
    int unsigned cycle_cnt   = 0;

    json_string_escaper i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // Watchdog
    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt > CYCLE_LIMIT) begin
            $display("json_string_escaper: mismatch");
            $finish;
        end
    end

    // Output monitor
    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            sb.check_char(m_axis_tdata, m_axis_tlast);
        end
    end

    // Receiver: random back-pressure, plus a long hold-off on request
    initial begin
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            @(posedge i_clk);
            if (hold_req) begin
                m_axis_tready <= 1'b0;
                for (int n = 0; n < HOLD_CYCLES; n++) begin
                    @(posedge i_clk);
                    hold_cnt++;
                end
                hold_req = 1'b0;
            end else begin
                m_axis_tready <= ($urandom_range(0, 99) >= rx_idle_pct);
            end
        end
    end

    // Offer one byte and wait for the request to be taken
    task automatic send_byte(input logic [7:0] b, input logic eos);
        while ($urandom_range(0, 99) < tx_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= b;
        s_axis_tlast  <= eos;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        sb.note_byte(b, eos);
    endtask

    function automatic logic pick_eos();
        return ($urandom_range(0, 9) == 0);
    endfunction

    // One random token: mostly well-formed UTF-8 or escapes, some noise
    task automatic send_token(inout int unsigned sent);
        int unsigned kind;
        int unsigned ncont;
        logic [7:0]  lead;
        logic [7:0]  cont;
        logic        eos;
        kind  = $urandom_range(0, 99);
        ncont = 0;
        if (kind < 10) begin
            lead = 8'($urandom_range(0, 255));
        end else if (kind < 25) begin
            case ($urandom_range(0, 8))
                0: lead = CH_QUOTE;
                1: lead = CH_APOS;
                2: lead = CH_BSLASH;
                3: lead = CH_SLASH;
                4: lead = CH_BS;
                5: lead = CH_FF;
                6: lead = CH_LF;
                7: lead = CH_CR;
                default: lead = CH_TAB;
            endcase
        end else if (kind < 35) begin
            lead = 8'($urandom_range(0, 31));
        end else if (kind < 55) begin
            lead = 8'($urandom_range(32, 127));
        end else if (kind < 70) begin
            lead  = 8'($urandom_range(128, 223));
            ncont = 1;
        end else if (kind < 82) begin
            lead  = 8'($urandom_range(224, 239));
            ncont = 2;
        end else if (kind < 92) begin
            lead  = 8'($urandom_range(240, 247));
            ncont = 3;
        end else begin
            lead = 8'($urandom_range(248, 255));
        end
        eos = pick_eos();
        send_byte(lead, eos);
        sent++;
        for (int i = 0; i < ncont && !eos; i++) begin
            if ($urandom_range(0, 99) < 8) begin
                cont = 8'($urandom_range(0, 255));
            end else begin
                cont = {2'b10, 6'($urandom_range(0, 63))};
            end
            eos = pick_eos();
            send_byte(cont, eos);
            sent++;
        end
    endtask

    // Directed bytes: bit 8 marks the end of a string
    logic [8:0] directed_seq [] = '{
        {1'b0, CH_QUOTE}, {1'b0, CH_APOS}, {1'b0, CH_BSLASH}, {1'b0, CH_SLASH},
        {1'b0, CH_BS}, {1'b0, CH_FF}, {1'b0, CH_LF}, {1'b0, CH_CR}, {1'b1, CH_TAB},
        9'h041, 9'h000, 9'h07F, 9'h1FF,
        9'h0C3, 9'h0A9,                    // two-byte sequence
        9'h0E2, 9'h082, 9'h0AC,            // three-byte sequence
        9'h0F7, 9'h0BF, 9'h0BF, 9'h0BF,    // largest four-byte code, six digits
        9'h0C0, 9'h0A2,                    // overlong quote: raw lead byte back
        9'h0E2, 9'h182                     // sequence cut short by end of string
    };

    initial begin
        int unsigned sent;
        int unsigned drain;
        bit          paused;
        sent   = 0;
        paused = 1'b0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (directed_seq[i]) begin
            send_byte(directed_seq[i][7:0], directed_seq[i][8]);
        end

        while (sent < RANDOM_BYTES) begin
            // quiet stretch with no idling on either side
            if (sent >= 100 && sent < 140) begin
                tx_idle_pct = 0;
                rx_idle_pct = 0;
            end else begin
                tx_idle_pct = 16;
                rx_idle_pct = 16;
            end
            // receiver holds off while bytes keep coming
            if (sent >= 60 && hold_cnt == 0 && !hold_req) hold_req = 1'b1;
            // sender pauses until the output side has caught up
            if (sent >= 170 && !paused) begin
                paused = 1'b1;
                s_axis_tvalid <= 1'b0;
                @(posedge i_clk);
                while (sb.outstanding() != 0) @(posedge i_clk);
            end
            send_token(sent);
        end
        s_axis_tvalid <= 1'b0;
        s_axis_tlast  <= 1'b0;

        while (sb.outstanding() != 0) @(posedge i_clk);
        for (drain = 0; drain < DRAIN_CYCLES; drain++) @(posedge i_clk);

        $display("Run covered %0d bytes over %0d strings, %0d escaped characters compared,",
                 sb.byte_cnt, sb.string_cnt, sb.char_cnt);
        $display("with one receiver hold-off of %0d cycles and random idling on both sides.",
                 hold_cnt);
        if (sb.err_cnt == 0) begin
            $display("json_string_escaper: match");
        end else begin
            $display("json_string_escaper: mismatch");
        end
        $finish;
    end

endmodule
